// ===== hw/rtl/pfa_pkg.sv =====
package pfa_pkg;

  // command codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_ALLOCATE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_LOADED    = 2'd0;
  localparam logic [1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [1:0] STATUS_WAIT      = 2'd2;

  // fit policies (code 3 behaves as first fit)
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // configuration register indexes
  localparam logic REG_FIT_MODE          = 1'b0;
  localparam logic REG_PARTITIONS_IN_USE = 1'b1;

  // port widths fixed by the interface
  localparam int SLOT_W = 4;
  localparam int SIZE_W = 16;
  localparam int MODE_W = 2;
  localparam int PIU_W  = 5;
  localparam int CFG_W  = 5;

endpackage

// ===== hw/rtl/pfa_ram.sv =====
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/partition_fit_allocator.sv =====
// Partition fit allocator.
// Input channel (in_valid / in_stall) carries one word: command, partition_slot,
// size_value. A load writes the free size of one partition; an allocate searches
// the first partitions_in_use entries of the free-size table by the policy in
// fit_mode (first, best or worst fit, ties to the lowest index) and shrinks the
// chosen entry by the request.
// Output channel (out_valid / out_stall) returns one word per input word:
// status, chosen_slot, free_left.
// Configuration: cfg_write with cfg_index and cfg_data; the user must write them
// only while idle, the block does not enforce this. Sequence: one word at a time.
// A load passes through the LOAD and REPLY states; an allocate through SCAN,
// UPDATE and REPLY, the scan reading at most min(partitions_in_use, PARTITIONS)
// entries from the table memory, one read per cycle with one compare unit. A new
// word is taken the cycle after the result moves into the output register.
// in_stall is high from the accept until the result moves into the output register.
// When the receiver stalls, the result waits in the output register; one more
// word may be accepted and processed, then the block holds it until the output
// register frees up.
// Reset: table reads as all zero (per-entry valid bits cleared), both config
// registers zero, no result pending. No clearing pass is needed.
module partition_fit_allocator #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [pfa_pkg::SLOT_W-1:0]  partition_slot,
  input  logic [pfa_pkg::SIZE_W-1:0]  size_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [pfa_pkg::SLOT_W-1:0]  chosen_slot,
  output logic [pfa_pkg::SIZE_W-1:0]  free_left
);
  import pfa_pkg::*;

  localparam int IW = $clog2(PARTITIONS);
  localparam int CW = $clog2(PARTITIONS + 1);

  typedef enum logic [2:0] {
    IDLE,
    LOAD,
    SCAN,
    UPDATE,
    REPLY
  } state_t;

  state_t state;

  // configuration registers
  logic [MODE_W-1:0] fit_mode;
  logic [PIU_W-1:0]  partitions_in_use;

  // latched word
  logic [SLOT_W-1:0]    slot;
  logic [SIZE_BITS-1:0] req;
  logic [CW-1:0]        count;

  // scan state
  logic [CW-1:0]        issue_idx;
  logic                 pend;
  logic [IW-1:0]        pidx;
  logic                 rd_valid;
  logic                 found;
  logic                 stop;
  logic [SIZE_BITS-1:0] best;
  logic [IW-1:0]        best_idx;

  // pending result
  logic [1:0]           res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [SIZE_BITS-1:0] res_left;

  // valid bits: an entry never written reads as zero
  logic [PARTITIONS-1:0] entry_valid;

  // memory ports
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  // derived values
  logic [31:0]          size_ext;
  logic [SIZE_BITS-1:0] size_in;
  logic [CW-1:0]        count_in;
  logic [31:0]          slot_ext;
  logic                 slot_ok;
  logic [31:0]          best_idx_ext;
  logic [31:0]          res_left_ext;
  logic                 in_accept;
  logic                 mode_best;
  logic                 mode_worst;
  logic                 mode_first;
  logic [SIZE_BITS-1:0] entry;
  logic                 ge_req;
  logic                 lt_best;
  logic                 gt_best;
  logic                 take;
  logic                 issue;
  logic                 fits;
  logic [SIZE_BITS-1:0] remain;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != IDLE);

  // request size kept to SIZE_BITS, entry count capped at PARTITIONS
  assign size_ext = 32'(size_value);
  assign size_in  = size_ext[SIZE_BITS-1:0];
  assign count_in = (32'(partitions_in_use) > PARTITIONS) ? CW'(PARTITIONS)
                                                          : CW'(partitions_in_use);

  assign slot_ext     = 32'(slot);
  assign slot_ok      = slot_ext < PARTITIONS;
  assign best_idx_ext = 32'(best_idx);
  assign res_left_ext = 32'(res_left);

  // policy decode
  assign mode_best  = (fit_mode == MODE_BEST);
  assign mode_worst = (fit_mode == MODE_WORST);
  assign mode_first = !mode_best && !mode_worst;

  // compare unit on the entry coming out of the memory
  assign entry   = rd_valid ? ram_rdata : '0;
  assign ge_req  = entry >= req;
  assign lt_best = entry < best;
  assign gt_best = entry > best;

  always_comb begin
    take = 1'b0;
    if (pend) begin
      priority if (mode_best) begin
        take = ge_req && (!found || lt_best);
      end else if (mode_worst) begin
        take = !found || gt_best;
      end else begin
        take = ge_req && !found;
      end
    end
  end

  // next read issued while entries remain and first fit has not hit
  assign issue = (state == SCAN) && (issue_idx < count) && !stop &&
                 !(mode_first && take);

  assign fits   = found && (best >= req);
  assign remain = best - req;

  // memory write port: load or allocation write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = remain;
    if (state == LOAD) begin
      ram_we    = slot_ok;
      ram_waddr = slot_ext[IW-1:0];
      ram_wdata = req;
    end else if (state == UPDATE) begin
      ram_we = fits;
    end
  end

  pfa_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(PARTITIONS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_idx[IW-1:0]),
    .rdata(ram_rdata)
  );

  // sequencer, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= IDLE;
      fit_mode          <= '0;
      partitions_in_use <= '0;
      entry_valid       <= '0;
      out_valid         <= 1'b0;
      pend              <= 1'b0;
      found             <= 1'b0;
      stop              <= 1'b0;
    end else begin
      // config writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FIT_MODE:          fit_mode          <= cfg_data[MODE_W-1:0];
          REG_PARTITIONS_IN_USE: partitions_in_use <= cfg_data[PIU_W-1:0];
          default: ;
        endcase
      end

      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end

      // output register drains on accept unless a new result replaces it
      if (out_valid && !out_stall && state != REPLY) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_accept) begin
            slot      <= partition_slot;
            req       <= size_in;
            count     <= count_in;
            issue_idx <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            stop      <= 1'b0;
            state     <= (command == CMD_LOAD) ? LOAD : SCAN;
          end
        end
        LOAD: begin
          res_status <= STATUS_LOADED;
          res_slot   <= slot;
          res_left   <= slot_ok ? req : '0;
          state      <= REPLY;
        end
        SCAN: begin
          // compare stage on last cycle's read
          if (take) begin
            found    <= 1'b1;
            best     <= entry;
            best_idx <= pidx;
            if (mode_first) begin
              stop <= 1'b1;
            end
          end
          // read stage
          if (issue) begin
            pend      <= 1'b1;
            pidx      <= issue_idx[IW-1:0];
            rd_valid  <= entry_valid[issue_idx[IW-1:0]];
            issue_idx <= issue_idx + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (fits) begin
            res_status <= STATUS_ALLOCATED;
            res_slot   <= best_idx_ext[SLOT_W-1:0];
            res_left   <= remain;
          end else begin
            res_status <= STATUS_WAIT;
            res_slot   <= '0;
            res_left   <= '0;
          end
          state <= REPLY;
        end
        REPLY: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            chosen_slot <= res_slot;
            free_left   <= res_left_ext[SIZE_W-1:0];
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pfa_checker.sv =====
module pfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [pfa_pkg::SLOT_W-1:0]  chosen_slot,
  input logic [pfa_pkg::SIZE_W-1:0]  free_left
);
  import pfa_pkg::*;

  // one word at a time: an accept is followed by a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(chosen_slot) && $stable(free_left)))
    else $error("stalled result changed");

  // only defined status codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_LOADED || status == STATUS_ALLOCATED ||
                   status == STATUS_WAIT))
    else $error("undefined status code");

  // a waiting request reports no slot and no size
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_WAIT) |-> (chosen_slot == '0 && free_left == '0))
    else $error("wait result carries slot or size");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .chosen_slot(chosen_slot),
  .free_left  (free_left)
);
